[hw/rtl/tte_pkg.sv]
// tte_pkg: constants, register indexes and sequencer states of the tap tempo estimator
// depends on nothing; imported by tap_tempo_estimator

package tte_pkg;

   // stamps kept between taps; one more slot holds the tap being worked on
   localparam int unsigned HISTORY_DEPTH = 8;
   localparam int unsigned STAMP_SLOTS   = HISTORY_DEPTH + 1;
   localparam int unsigned COUNT_W       = $clog2(STAMP_SLOTS + 1);
   localparam int unsigned SLOT_IDX_W    = $clog2(STAMP_SLOTS);

   // fixed field widths
   localparam int unsigned STAMP_W     = 32;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned TEMPO_W     = 16;
   localparam int unsigned TAPS_USED_W = 4;

   // tenths of bpm times milliseconds per minute
   localparam int unsigned TENTHS_PER_MINUTE = 600000;
   localparam int unsigned NUM_W = $clog2(TENTHS_PER_MINUTE * HISTORY_DEPTH + 1);

   // divider: dividend 2*num + span, divisor 2*span
   localparam int unsigned DIVIDEND_W = (((NUM_W + 1) > STAMP_W) ? (NUM_W + 1) : STAMP_W) + 1;
   localparam int unsigned DIVISOR_W  = STAMP_W + 1;
   localparam int unsigned STEP_W     = $clog2(DIVIDEND_W);

   // register reset values
   localparam logic [CSR_DATA_W-1:0] TIMEOUT_RESET = 16'd2000;
   localparam logic [CSR_DATA_W-1:0] MIN_RESET     = 16'd10;
   localparam logic [CSR_DATA_W-1:0] MAX_RESET     = 16'd9600;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT_MS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMPO_MIN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMPO_MAX  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MULT = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } seq_state_type;

endpackage

[hw/rtl/tap_tempo_estimator.sv]
// tap_tempo_estimator: tap history, timeout clear, tempo estimate with a serial restoring divider
// depends on tte_pkg

// Each req transfer is one tap carrying a free-running millisecond stamp; each tap gives
// exactly one rsp transfer. A gap above timeout_ms since the previous tap drops the stored
// history (history_cleared is set when stamps were actually dropped). With two or more
// stamps the tempo in tenths of bpm is 600000*(n-1)/(newest-oldest), rounded to nearest
// and clamped to the configured floor and ceiling (ceiling wins if they cross); equal
// newest and oldest stamps give the ceiling. Up to HISTORY_DEPTH+1 stamps take part, then
// the oldest is dropped. A tap steps through MULT, LOAD, DIV and DONE; the radix-2 restoring
// divider in DIV retires one quotient bit a cycle. A tap with no estimate, or a zero span,
// skips LOAD and DIV and goes from MULT to DONE. req_ready is low while a tap is in flight.
// The result sits in an output register, so a new tap is taken while the previous result
// still waits on rsp_ready. Configuration writes are always taken and should be done while
// the block is idle.

module tap_tempo_estimator
   import tte_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [STAMP_W-1:0]     req_tap_time_ms,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [TEMPO_W-1:0]     rsp_tempo_tenths,
   output logic                   rsp_tempo_valid,
   output logic [TAPS_USED_W-1:0] rsp_taps_used,
   output logic                   rsp_history_cleared,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [CSR_DATA_W-1:0] timeout_ff, min_ff, max_ff;

   // sequencer
   seq_state_type state_ff, state_in;

   // tap history, oldest stamp at slot zero
   logic [STAMP_W-1:0] stamps_ff [STAMP_SLOTS];
   logic [STAMP_W-1:0] stamps_in [STAMP_SLOTS];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [STAMP_W-1:0] prev_ff;

   // per-tap working values
   logic [COUNT_W-1:0]    used_ff, used_in;
   logic                  cleared_ff, cleared_in;
   logic [STAMP_W-1:0]    span_ff, span_in;
   logic [NUM_W-1:0]      num_ff;

   // divider
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  divisor_ff;
   logic [STEP_W-1:0]     step_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [TEMPO_W-1:0]     rsp_tempo_ff;
   logic                   rsp_est_ff;
   logic [TAPS_USED_W-1:0] rsp_used_ff;
   logic                   rsp_cleared_ff;

   logic                  req_xfer;
   logic                  rsp_free;
   logic [STAMP_W-1:0]    gap;
   logic                  timed_out;
   logic [COUNT_W-1:0]    count_eff;
   logic [STAMP_W-1:0]    oldest;
   logic                  trim;
   logic [STAMP_W-1:0]    written [STAMP_SLOTS];
   logic [DIVISOR_W:0]    trial;
   logic                  fits;
   logic                  has_estimate;
   logic [TEMPO_W-1:0]    tempo_final;
   logic [DIVIDEND_W-1:0] raised;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tempo_tenths    = rsp_tempo_ff;
   assign rsp_tempo_valid     = rsp_est_ff;
   assign rsp_taps_used       = rsp_used_ff;
   assign rsp_history_cleared = rsp_cleared_ff;

   // tap intake: timeout check, append, span and trim all in the transfer cycle
   always_comb begin
      gap       = req_tap_time_ms - prev_ff;
      timed_out = gap > STAMP_W'(timeout_ff);
      count_eff = timed_out ? '0 : count_ff;
      cleared_in = timed_out && (count_ff != '0);
      used_in   = count_eff + COUNT_W'(1);
      // with an empty history the new stamp is also the oldest
      oldest    = (count_eff == '0) ? req_tap_time_ms : stamps_ff[0];
      span_in   = req_tap_time_ms - oldest;
      trim      = used_in > COUNT_W'(HISTORY_DEPTH);
      count_in  = trim ? COUNT_W'(HISTORY_DEPTH) : used_in;
      for (int i = 0; i < STAMP_SLOTS; i++) begin
         written[i] = (count_eff == COUNT_W'(i)) ? req_tap_time_ms : stamps_ff[i];
      end
      for (int i = 0; i < STAMP_SLOTS; i++) begin
         if (trim && (i < STAMP_SLOTS - 1)) begin
            stamps_in[i] = written[(i + 1) % STAMP_SLOTS];
         end else begin
            stamps_in[i] = written[i];
         end
      end
   end

   // one restoring divider step
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits  = trial >= {1'b0, divisor_ff};
   end

   // result selection and clamp
   always_comb begin
      has_estimate = used_ff >= COUNT_W'(2);
      raised = (quo_ff < DIVIDEND_W'(min_ff)) ? DIVIDEND_W'(min_ff) : quo_ff;
      if (!has_estimate) begin
         tempo_final = '0;
      end else if (span_ff == '0) begin
         tempo_final = max_ff;
      end else if (raised > DIVIDEND_W'(max_ff)) begin
         tempo_final = max_ff;
      end else begin
         tempo_final = raised[TEMPO_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_MULT;
         end
         ST_MULT: begin
            if ((used_ff < COUNT_W'(2)) || (span_ff == '0)) state_in = ST_DONE;
            else state_in = ST_LOAD;
         end
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == '0) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TIMEOUT_MS: timeout_ff <= csr_wdata;
               REG_TEMPO_MIN:  min_ff     <= csr_wdata;
               REG_TEMPO_MAX:  max_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (req_xfer) begin
            count_ff <= count_in;
            prev_ff  <= req_tap_time_ms;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stamps_ff  <= stamps_in;
         used_ff    <= used_in;
         cleared_ff <= cleared_in;
         span_ff    <= span_in;
      end
      if (state_ff == ST_MULT) begin
         num_ff <= NUM_W'(TENTHS_PER_MINUTE * (used_ff - COUNT_W'(1)));
      end
      if (state_ff == ST_LOAD) begin
         // adding span before halving the quotient rounds half up
         rem_ff     <= '0;
         quo_ff     <= DIVIDEND_W'({num_ff, 1'b0}) + DIVIDEND_W'(span_ff);
         divisor_ff <= {span_ff, 1'b0};
         step_ff    <= STEP_W'(DIVIDEND_W - 1);
      end
      if (state_ff == ST_DIV) begin
         rem_ff  <= fits ? DIVISOR_W'(trial - {1'b0, divisor_ff}) : trial[DIVISOR_W-1:0];
         quo_ff  <= {quo_ff[DIVIDEND_W-2:0], fits};
         step_ff <= step_ff - STEP_W'(1);
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_tempo_ff   <= tempo_final;
         rsp_est_ff     <= has_estimate;
         rsp_used_ff    <= TAPS_USED_W'(used_ff);
         rsp_cleared_ff <= cleared_ff;
      end
   end

endmodule
